FILE: hw/rtl/twma_pkg.sv
// Shared types, state codes and saturation helpers for the time-weighted moving average.
// Used by twma_mul, twma_div and time_weighted_moving_average.
package twma_pkg;

  localparam int DEPTH_DEF = 64;
  localparam logic [23:0] WINDOW_RESET = 24'd30000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] value_a;
    logic signed [23:0] value_b;
    logic [47:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] average_a;
    logic signed [23:0] average_b;
    logic [6:0]         entries;
    logic               forced_evict;
    logic               time_reset;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_EV_RD, ST_EV_MA, ST_EV_MB, ST_ADD_MA, ST_ADD_MB,
    ST_APPEND, ST_AVG, ST_DIV_A, ST_DIV_B, ST_DONE
  } state_t;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [23:0] sat24(logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

FILE: hw/rtl/twma_mul.sv
// Bit-serial signed 24 x unsigned 48 multiplier, one multiplier bit per cycle,
// result saturated to signed 64 bits. Depends on twma_pkg.
module twma_mul import twma_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [23:0] value,
  input  logic [47:0]        dur,
  output logic               done,
  output logic signed [63:0] product
);

  logic [23:0] mag_r;
  logic [47:0] dur_r;
  logic [71:0] acc_r;
  logic        neg_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic signed [63:0] prod_r;
  logic [48:0] hi;
  logic [71:0] acc_nxt;

  assign hi      = {1'b0, acc_r[71:24]} + (mag_r[0] ? {1'b0, dur_r} : 49'd0);
  assign acc_nxt = {hi, acc_r[23:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mag_r  <= value[23] ? 24'(-value) : value;
        neg_r  <= value[23];
        dur_r  <= dur;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        mag_r <= mag_r >> 1;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd23) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (!neg_r) begin
            prod_r <= (acc_nxt[71:63] != '0) ? S64_MAX : acc_nxt[63:0];
          end else begin
            prod_r <= (acc_nxt[71:63] != '0) ? S64_MIN : -$signed(acc_nxt[63:0]);
          end
        end
      end
    end
  end

  assign done    = done_r;
  assign product = prod_r;

endmodule

FILE: hw/rtl/twma_div.sv
// Restoring divider: signed 64-bit total over unsigned 48-bit span, one quotient
// bit per cycle, truncated toward zero and saturated to Q15.8. Depends on twma_pkg.
module twma_div import twma_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic [47:0]        divisor,
  output logic               done,
  output logic signed [23:0] quotient
);

  logic [63:0] dq_r;
  logic [47:0] rem_r;
  logic [47:0] div_r;
  logic        neg_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic signed [23:0] q_r;
  logic [48:0] r2;
  logic        ge;
  logic [63:0] dq_nxt;

  assign r2     = {rem_r, dq_r[63]};
  assign ge     = r2 >= {1'b0, div_r};
  assign dq_nxt = {dq_r[62:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dq_r   <= dividend[63] ? 64'(-dividend) : dividend;
        neg_r  <= dividend[63];
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? 48'(r2 - {1'b0, div_r}) : r2[47:0];
        dq_r  <= dq_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (!neg_r) begin
            q_r <= (dq_nxt > 64'd8388607) ? 24'sh7FFFFF : dq_nxt[23:0];
          end else begin
            q_r <= (dq_nxt > 64'd8388608) ? 24'sh800000 : 24'(-dq_nxt[23:0]);
          end
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/time_weighted_moving_average.sv
// Top level of the time-weighted moving average over two Q15.8 channels.
// Depends on twma_pkg, twma_mul and twma_div.
//
// Channels: in_valid/in_ready carry one in_item_t beat, out_valid/out_ready one
// out_item_t beat per input beat. cfg_valid/cfg_ready write window_ms, taken
// in any cycle; write it only while the block is idle.
// One item is in flight at a time. A start beat goes through ST_AVG and ST_DONE.
// A sample beat goes through ST_CHECK, two serial multiplies per evicted sample,
// two for its add, ST_APPEND, ST_AVG, two serial divisions when the span is
// nonzero, and ST_DONE, which loads the output register.
// The sample store is a RAM of DEPTH entries with one write port and one
// registered read port at the oldest slot; the newest timestamp is kept in a
// register.
// Reset (rst_n low, synchronous) empties the store, clears the totals and the
// window start and sets window_ms to 30000; no clearing pass is needed.
// A finished result is held in the output register while the receiver stalls;
// the next input beat is taken meanwhile and waits at its end for the slot.
module time_weighted_moving_average import twma_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_window_ms
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  logic [23:0] win_r;
  logic [47:0] ws_r, ws_nxt, newest_r, newest_nxt, dur_r, dur_nxt;
  logic signed [63:0] tot_a_r, tot_a_nxt, tot_b_r, tot_b_nxt;
  logic signed [23:0] avg_a_r, avg_a_nxt, avg_b_r, avg_b_nxt;
  logic [PW-1:0] old_r, old_nxt, wr_r, wr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic forced_r, forced_nxt, treset_r, treset_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic [95:0] mem [DEPTH];
  logic [95:0] rd_r;
  logic        wr_en;

  logic               mul_start, mul_done, div_start, div_done;
  logic signed [23:0] mul_val, div_q;
  logic [47:0]        mul_dur, ev_dur, ref_t, span;
  logic signed [63:0] mul_p, div_n;

  assign ev_dur = rd_r[47:0] - ws_r;
  assign ref_t  = (cnt_r != '0) ? newest_r : ws_r;
  assign span   = newest_r - ws_r;

  twma_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .value(mul_val), .dur(mul_dur),
    .done(mul_done), .product(mul_p)
  );

  twma_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n), .divisor(span),
    .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_r] <= {item_r.value_a, item_r.value_b, item_r.time_ms};
    end
    rd_r <= mem[old_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= WINDOW_RESET;
      ws_r        <= '0;
      tot_a_r     <= '0;
      tot_b_r     <= '0;
      old_r       <= '0;
      wr_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid) begin
        win_r <= cfg_window_ms;
      end
      ws_r        <= ws_nxt;
      tot_a_r     <= tot_a_nxt;
      tot_b_r     <= tot_b_nxt;
      old_r       <= old_nxt;
      wr_r        <= wr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r   <= item_nxt;
    newest_r <= newest_nxt;
    dur_r    <= dur_nxt;
    avg_a_r  <= avg_a_nxt;
    avg_b_r  <= avg_b_nxt;
    forced_r <= forced_nxt;
    treset_r <= treset_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    ws_nxt        = ws_r;
    newest_nxt    = newest_r;
    dur_nxt       = dur_r;
    tot_a_nxt     = tot_a_r;
    tot_b_nxt     = tot_b_r;
    avg_a_nxt     = avg_a_r;
    avg_b_nxt     = avg_b_r;
    old_nxt       = old_r;
    wr_nxt        = wr_r;
    cnt_nxt       = cnt_r;
    forced_nxt    = forced_r;
    treset_nxt    = treset_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    mul_start     = 1'b0;
    mul_val       = item_r.value_a;
    mul_dur       = dur_r;
    div_start     = 1'b0;
    div_n         = tot_a_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_item;
          forced_nxt = 1'b0;
          treset_nxt = 1'b0;
          if (!in_item.kind) begin
            cnt_nxt   = '0;
            old_nxt   = '0;
            wr_nxt    = '0;
            tot_a_nxt = '0;
            tot_b_nxt = '0;
            ws_nxt    = in_item.time_ms;
            state_nxt = ST_AVG;
          end else begin
            if (cnt_r == '0) begin
              ws_nxt = in_item.time_ms;
            end
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (cnt_r != '0 && ({1'b0, ws_r} + 49'(win_r)) < {1'b0, newest_r}) begin
          state_nxt = ST_EV_RD;
        end else if (item_r.time_ms < ref_t) begin
          cnt_nxt    = '0;
          old_nxt    = '0;
          wr_nxt     = '0;
          tot_a_nxt  = '0;
          tot_b_nxt  = '0;
          ws_nxt     = item_r.time_ms;
          treset_nxt = 1'b1;
          state_nxt  = ST_AVG;
        end else begin
          dur_nxt   = item_r.time_ms - ref_t;
          mul_dur   = item_r.time_ms - ref_t;
          mul_start = 1'b1;
          state_nxt = ST_ADD_MA;
        end
      end
      ST_EV_RD: begin
        mul_val   = rd_r[95:72];
        mul_dur   = ev_dur;
        mul_start = 1'b1;
        state_nxt = ST_EV_MA;
      end
      ST_EV_MA: begin
        if (mul_done) begin
          tot_a_nxt = sat_sub(tot_a_r, mul_p);
          mul_val   = rd_r[71:48];
          mul_dur   = ev_dur;
          mul_start = 1'b1;
          state_nxt = ST_EV_MB;
        end
      end
      ST_EV_MB: begin
        if (mul_done) begin
          tot_b_nxt = sat_sub(tot_b_r, mul_p);
          ws_nxt    = rd_r[47:0];
          old_nxt   = (old_r == PW'(DEPTH - 1)) ? '0 : old_r + 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = forced_r ? ST_APPEND : ST_CHECK;
        end
      end
      ST_ADD_MA: begin
        if (mul_done) begin
          tot_a_nxt = sat_add(tot_a_r, mul_p);
          mul_val   = item_r.value_b;
          mul_start = 1'b1;
          state_nxt = ST_ADD_MB;
        end
      end
      ST_ADD_MB: begin
        if (mul_done) begin
          tot_b_nxt = sat_add(tot_b_r, mul_p);
          if (cnt_r == CW'(DEPTH)) begin
            forced_nxt = 1'b1;
            state_nxt  = ST_EV_RD;
          end else begin
            state_nxt = ST_APPEND;
          end
        end
      end
      ST_APPEND: begin
        wr_en      = 1'b1;
        wr_nxt     = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        newest_nxt = item_r.time_ms;
        state_nxt  = ST_AVG;
      end
      ST_AVG: begin
        if (cnt_r == '0) begin
          avg_a_nxt = '0;
          avg_b_nxt = '0;
          state_nxt = ST_DONE;
        end else if (span == '0) begin
          avg_a_nxt = sat24(tot_a_r);
          avg_b_nxt = sat24(tot_b_r);
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        if (div_done) begin
          avg_a_nxt = div_q;
          div_n     = tot_b_r;
          div_start = 1'b1;
          state_nxt = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        if (div_done) begin
          avg_b_nxt = div_q;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_nxt.average_a    = avg_a_r;
          out_nxt.average_b    = avg_b_r;
          out_nxt.entries      = 7'(cnt_r);
          out_nxt.forced_evict = forced_r;
          out_nxt.time_reset   = treset_r;
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign cfg_ready = 1'b1;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("store count above depth");
  a_forced_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && forced_r) |-> cnt_r == CW'(DEPTH))
    else $error("forced eviction without a full store");
  a_treset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && treset_r) |-> cnt_r == '0)
    else $error("time reset left samples stored");
  a_single_ev: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EV_RD) |=> state_r == ST_EV_MA)
    else $error("eviction read not followed by multiply");

endmodule

FILE: sim/twma_checker.sv
// Checker for the time-weighted moving average: watches the input, output and
// window write channels, predicts each result and compares it. Depends on twma_pkg.
module twma_checker import twma_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [23:0] cfg_window_ms,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [23:0] hist_a [DEPTH];
  logic signed [23:0] hist_b [DEPTH];
  logic [47:0]        hist_t [DEPTH];
  int                 head;
  int                 fill;
  logic signed [63:0] sum_a;
  logic signed [63:0] sum_b;
  logic [47:0]        win_start;
  logic [23:0]        win_len;
  out_item_t          expected_q[$];

  function automatic logic signed [63:0] weigh(logic signed [23:0] v, logic [47:0] d);
    logic signed [127:0] p;
    p = 128'(signed'(v)) * $signed({80'd0, d});
    if (p > 128'(S64_MAX)) return S64_MAX;
    if (p < 128'(S64_MIN)) return S64_MIN;
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] s_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] s_sub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [23:0] mean(logic signed [63:0] tot, logic [47:0] span);
    logic signed [63:0] q;
    q = (span != 0) ? tot / $signed({16'd0, span}) : tot;
    if (q > 64'sd8388607) return 24'sh7FFFFF;
    if (q < -64'sd8388608) return 24'sh800000;
    return q[23:0];
  endfunction

  function automatic int newest();
    return (head + fill - 1) % DEPTH;
  endfunction

  task automatic drop_oldest();
    logic [47:0] d;
    d = hist_t[head] - win_start;
    sum_a = s_sub(sum_a, weigh(hist_a[head], d));
    sum_b = s_sub(sum_b, weigh(hist_b[head], d));
    win_start = hist_t[head];
    head = (head + 1) % DEPTH;
    fill--;
  endtask

  task automatic predict_average(in_item_t it);
    out_item_t r;
    logic [47:0] ref_t;
    logic [48:0] lim;
    logic [47:0] dur;
    logic [47:0] span;
    r = '0;
    if (!it.kind) begin
      fill = 0; head = 0; sum_a = 0; sum_b = 0; win_start = it.time_ms;
    end else begin
      if (fill == 0) win_start = it.time_ms;
      forever begin
        lim = {1'b0, win_start} + win_len;
        if (fill > 0 && lim < {1'b0, hist_t[newest()]}) drop_oldest();
        else break;
      end
      ref_t = (fill > 0) ? hist_t[newest()] : win_start;
      if (it.time_ms < ref_t) begin
        fill = 0; head = 0; sum_a = 0; sum_b = 0; win_start = it.time_ms;
        r.time_reset = 1'b1;
      end else begin
        dur = it.time_ms - ref_t;
        sum_a = s_add(sum_a, weigh(it.value_a, dur));
        sum_b = s_add(sum_b, weigh(it.value_b, dur));
        if (fill >= DEPTH) begin
          drop_oldest();
          r.forced_evict = 1'b1;
        end
        hist_a[(head + fill) % DEPTH] = it.value_a;
        hist_b[(head + fill) % DEPTH] = it.value_b;
        hist_t[(head + fill) % DEPTH] = it.time_ms;
        fill++;
      end
    end
    if (fill > 0) begin
      span = hist_t[newest()] - win_start;
      r.average_a = mean(sum_a, span);
      r.average_b = mean(sum_b, span);
    end
    r.entries = 7'(fill);
    expected_q.push_back(r);
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      head = 0; fill = 0; sum_a = 0; sum_b = 0; win_start = 0;
      win_len = WINDOW_RESET;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) win_len = cfg_window_ms;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %p", out_item);
        end else begin
          e = expected_q.pop_front();
          if (e.average_a !== out_item.average_a || e.average_b !== out_item.average_b ||
              e.entries !== out_item.entries || e.forced_evict !== out_item.forced_evict ||
              e.time_reset !== out_item.time_reset) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p actual %p", e, out_item);
          end
        end
      end
      if (in_valid && in_ready) predict_average(in_item);
    end
  end
endmodule

FILE: sim/time_weighted_moving_average_tb.sv
// Testbench top for time_weighted_moving_average: drives sample, start and window
// beats with random gaps and stalls; twma_checker predicts and compares results.
module time_weighted_moving_average_tb import twma_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_window_ms = '0;
  int          fail_count;
  int          pending;
  logic [47:0] clock_ms = 48'd1000;
  int          hold_off = 0;
  int          rx_wait = 0;
  bit          long_stall = 1'b0;
  bit          stall_seen = 1'b0;
  bit          out_taken = 1'b0;

  always #5 clk = ~clk;

  time_weighted_moving_average DUT (.*);
  twma_checker #(.DEPTH(DEPTH_DEF)) u_checker (.*);

  task automatic send_beat(logic kind, logic signed [23:0] va, logic signed [23:0] vb,
                           logic [47:0] t);
    repeat ($urandom_range(0, 8)) @(negedge clk);
    in_item <= '{kind: kind, value_a: va, value_b: vb, time_ms: t};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic set_window(logic [23:0] w);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    @(negedge clk);
    cfg_window_ms <= w;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [23:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'(signed'($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic run_samples(int n, int max_step);
    logic [47:0] t;
    repeat (n) begin
      case ($urandom_range(0, 39))
        0: send_beat(1'b0, rand_value(), rand_value(), clock_ms);
        1: send_beat(1'b1, rand_value(), rand_value(), clock_ms - $urandom_range(1, 500));
        2: send_beat(1'b1, rand_value(), rand_value(), 48'({$urandom, $urandom}));
        default: begin
          t = clock_ms + $urandom_range(0, max_step);
          send_beat(1'b1, rand_value(), rand_value(), t);
          clock_ms = t;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    out_taken <= out_valid && out_ready;
  end

  always @(negedge clk) begin
    int w;
    w = $urandom_range(0, 8);
    if (long_stall && !stall_seen) begin
      stall_seen <= 1'b1;
      hold_off   <= 3000;
      out_ready  <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off  <= hold_off - 1;
    end else if (out_taken) begin
      rx_wait   <= w;
      out_ready <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_beat(1'b1, 24'sh7FFFFF, 24'sh800000, 48'd0);
    send_beat(1'b1, 24'sh7FFFFF, 24'sh800000, 48'hFFFF_FFFF_FFFF);
    send_beat(1'b1, 24'sh000100, 24'sh000000, 48'h0);
    send_beat(1'b0, 24'sh000000, 24'sh000000, 48'd100);
    send_beat(1'b1, 24'sh000100, -24'sh000200, 48'd100);
    send_beat(1'b1, 24'sh000300, 24'sh000001, 48'd150);
    send_beat(1'b1, -24'sh000001, 24'sh000001, 48'd250);
    send_beat(1'b1, 24'sh000010, 24'sh000010, 48'd40000);
    send_beat(1'b1, 24'sh000020, 24'sh000020, 48'd40000);
    send_beat(1'b1, 24'sh000020, 24'sh000020, 48'd39999);
    send_beat(1'b0, 24'sh7FFFFF, 24'sh800000, 48'hFFFF_FFFF_FFFF);
    send_beat(1'b1, 24'sh000001, 24'sh000001, 48'hFFFF_FFFF_FFFF);
    send_beat(1'b0, 24'sh000000, 24'sh000000, 48'd0);
    for (int i = 0; i < 70; i++) send_beat(1'b1, rand_value(), rand_value(), 48'(i * 3));
    long_stall = 1'b1;
    run_samples(20, 50);
    set_window(24'hFFFFFF);
    run_samples(200, 100000);
    set_window(24'd1);
    run_samples(150, 3);
    set_window(24'd0);
    run_samples(100, 2);
    set_window(24'd500);
    run_samples(200, 40);
    set_window(24'($urandom));
    run_samples(130, 1000);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end
endmodule
